// ----- hw/rtl/pcbi_pkg.sv -----
// Shared types, constants and helpers of the periodic cell bin index unit.
package pcbi_pkg;

  localparam int COORD_BITS     = 24;
  localparam int COEF_BITS      = 16;
  localparam int CELL_BITS      = 21;
  localparam int DIM_BITS       = 10;
  localparam int IDX_BITS       = 21;
  localparam int SHIFT_OUT_BITS = 16;
  localparam int FRAC_SHIFT     = 22;
  localparam int OFF_SCALE      = 14;
  localparam int PROD_BITS      = COEF_BITS + COORD_BITS;
  localparam int ACC_BITS       = PROD_BITS + 2;
  localparam int BIN_BITS       = ACC_BITS - FRAC_SHIFT;
  localparam int MAG_BITS       = BIN_BITS;
  localparam int DIV_STEPS      = 4;
  localparam int DIV_STAGES     = MAG_BITS / DIV_STEPS;
  localparam int SHIFT_BITS     = MAG_BITS + 1;
  localparam int WPROD_BITS     = SHIFT_BITS + CELL_BITS;
  localparam int WSUM_BITS      = WPROD_BITS + 3;
  localparam int IDX_SUM_BITS   = 3 * DIM_BITS + 1;
  localparam int BIN_COUNT_LIMIT = 2097152;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CELL_VEC_BITS  = 3 * CELL_BITS;
  localparam int GEOM_BITS      = 3 * DIM_BITS + 3;
  localparam int PERIODIC_LSB   = 3 * DIM_BITS;

  localparam logic [GEOM_BITS-1:0] GEOM_RESET = GEOM_BITS'(1049601);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIP_X  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIP_Y  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIP_Z  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CELL_A   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CELL_B   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CELL_C   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GEOMETRY = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         selected;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]              bin_index;
    logic                             binned;
    logic signed [SHIFT_OUT_BITS-1:0] image_shift_a;
    logic signed [SHIFT_OUT_BITS-1:0] image_shift_b;
    logic signed [SHIFT_OUT_BITS-1:0] image_shift_c;
    logic signed [COORD_BITS-1:0]     wrapped_x;
    logic signed [COORD_BITS-1:0]     wrapped_y;
    logic signed [COORD_BITS-1:0]     wrapped_z;
  } rsp_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [WSUM_BITS-1:0] v);
    logic signed [WSUM_BITS-1:0] hi;
    logic signed [WSUM_BITS-1:0] lo;
    hi = WSUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    lo = -hi - WSUM_BITS'(1);
    if (v > hi) return hi[COORD_BITS-1:0];
    if (v < lo) return lo[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [SHIFT_OUT_BITS-1:0] sat_shift(
      input logic signed [SHIFT_BITS-1:0] v);
    logic signed [SHIFT_BITS-1:0] hi;
    logic signed [SHIFT_BITS-1:0] lo;
    hi = SHIFT_BITS'((32'sd1 <<< (SHIFT_OUT_BITS - 1)) - 32'sd1);
    lo = -hi - SHIFT_BITS'(1);
    if (v > hi) return hi[SHIFT_OUT_BITS-1:0];
    if (v < lo) return lo[SHIFT_OUT_BITS-1:0];
    return v[SHIFT_OUT_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/pcbi_div_stage.sv -----
// One stage of the restoring divider: several quotient bits per stage.
module pcbi_div_stage (
  input  logic [pcbi_pkg::DIM_BITS-1:0] dim,
  input  logic [pcbi_pkg::DIM_BITS-1:0] rem_in,
  input  logic [pcbi_pkg::MAG_BITS-1:0] qd_in,
  output logic [pcbi_pkg::DIM_BITS-1:0] rem_out,
  output logic [pcbi_pkg::MAG_BITS-1:0] qd_out
);
  import pcbi_pkg::*;

  always_comb begin
    logic [DIM_BITS-1:0] rem;
    logic [MAG_BITS-1:0] qd;
    logic [DIM_BITS:0]   t;
    rem = rem_in;
    qd  = qd_in;
    for (int s = 0; s < DIV_STEPS; s++) begin
      t  = {rem, qd[MAG_BITS-1]};
      qd = {qd[MAG_BITS-2:0], 1'b0};
      if (t >= {1'b0, dim}) begin
        t     = t - {1'b0, dim};
        qd[0] = 1'b1;
      end
      rem = t[DIM_BITS-1:0];
    end
    rem_out = rem;
    qd_out  = qd;
  end

endmodule

// ----- hw/rtl/periodic_cell_bin_index_unit.sv -----
// Top level of the periodic cell bin index unit: pipeline and register file.
// The unit takes one particle request per cycle when the output side keeps up.
// The ten stages are: coefficient products, affine sum and
// floor, five stages of a restoring divider that wraps periodic bins (four quotient bits
// per stage), image shift and bin selection, shift and index products, and final sums with
// saturation into the output register. Each stage holds its request while the next one is
// full, so a stalled output stops only the stages that have no room. Configuration writes
// take effect at once and are to be made while no request is in flight.
module periodic_cell_bin_index_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  pcbi_pkg::req_t                       req_data,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output pcbi_pkg::rsp_t                       rsp_data,
  input  logic                                 cfg_we,
  input  logic [pcbi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pcbi_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import pcbi_pkg::*;

  localparam int NSTAGE = DIV_STAGES + 5;
  localparam int DV0    = 2;
  localparam int P1     = DV0 + DIV_STAGES;
  localparam int P2     = P1 + 1;
  localparam int P3     = P2 + 1;

  logic [CFG_DATA_BITS-1:0] recip [3];
  logic [CELL_VEC_BITS-1:0] cellv [3];
  logic [GEOM_BITS-1:0]     geom;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        recip[k] <= '0;
        cellv[k] <= '0;
      end
      geom <= GEOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RECIP_X:  recip[0] <= cfg_wdata;
        CFG_RECIP_Y:  recip[1] <= cfg_wdata;
        CFG_RECIP_Z:  recip[2] <= cfg_wdata;
        CFG_CELL_A:   cellv[0] <= cfg_wdata[CELL_VEC_BITS-1:0];
        CFG_CELL_B:   cellv[1] <= cfg_wdata[CELL_VEC_BITS-1:0];
        CFG_CELL_C:   cellv[2] <= cfg_wdata[CELL_VEC_BITS-1:0];
        CFG_GEOMETRY: geom     <= cfg_wdata[GEOM_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_BITS-1:0]         dim      [3];
  logic                        periodic [3];
  logic signed [COEF_BITS-1:0] coef     [3][3];
  logic signed [COEF_BITS-1:0] offs     [3];
  logic signed [CELL_BITS-1:0] cvec     [3][3];
  logic [2*DIM_BITS-1:0]       dim01;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dim[k] = geom[DIM_BITS*k +: DIM_BITS];
      if (dim[k] == '0) dim[k] = DIM_BITS'(1);
      periodic[k] = geom[PERIODIC_LSB + k];
      offs[k] = recip[k][3*COEF_BITS +: COEF_BITS];
      for (int j = 0; j < 3; j++) begin
        coef[k][j] = recip[k][COEF_BITS*j +: COEF_BITS];
        cvec[k][j] = cellv[k][CELL_BITS*j +: CELL_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    dim01 <= dim[0] * dim[1];
  end

  logic v  [NSTAGE];
  logic en [NSTAGE];

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || rsp_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign req_ready = en[0];
  assign rsp_valid = v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGE; i++) v[i] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= req_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  logic signed [COORD_BITS-1:0] req_pos [3];
  assign req_pos[0] = req_data.pos_x;
  assign req_pos[1] = req_data.pos_y;
  assign req_pos[2] = req_data.pos_z;

  // Stage 1: products.
  logic signed [PROD_BITS-1:0]  s1_prod [3][3];
  logic signed [COEF_BITS-1:0]  s1_off  [3];
  logic signed [COORD_BITS-1:0] s1_pos  [3];
  logic                         s1_sel;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        s1_off[k] <= offs[k];
        s1_pos[k] <= req_pos[k];
        for (int j = 0; j < 3; j++) begin
          s1_prod[k][j] <= coef[k][j] * req_pos[j];
        end
      end
      s1_sel <= req_data.selected;
    end
  end

  // Stage 2: sum, floor, magnitude for the divider and clamped bin.
  logic signed [ACC_BITS-1:0]   acc [3];
  logic signed [BIN_BITS-1:0]   bin_raw [3];
  logic [MAG_BITS-1:0]          s2_qd  [3];
  logic                         s2_neg [3];
  logic [DIM_BITS-1:0]          s2_cl  [3];
  logic signed [COORD_BITS-1:0] s2_pos [3];
  logic                         s2_sel;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = (ACC_BITS'(s1_off[k]) <<< OFF_SCALE) + ACC_BITS'(s1_prod[k][0])
             + ACC_BITS'(s1_prod[k][1]) + ACC_BITS'(s1_prod[k][2]);
      bin_raw[k] = acc[k][ACC_BITS-1:FRAC_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s2_neg[k] <= bin_raw[k][BIN_BITS-1];
        s2_qd[k]  <= bin_raw[k][BIN_BITS-1] ? ~bin_raw[k] : bin_raw[k];
        if (bin_raw[k][BIN_BITS-1]) begin
          s2_cl[k] <= '0;
        end else if (bin_raw[k] >= $signed({{(BIN_BITS-DIM_BITS){1'b0}}, dim[k]})) begin
          s2_cl[k] <= dim[k] - DIM_BITS'(1);
        end else begin
          s2_cl[k] <= bin_raw[k][DIM_BITS-1:0];
        end
        s2_pos[k] <= s1_pos[k];
      end
      s2_sel <= s1_sel;
    end
  end

  // Divider stages.
  logic [DIM_BITS-1:0]          dv_rem [DIV_STAGES][3];
  logic [MAG_BITS-1:0]          dv_qd  [DIV_STAGES][3];
  logic                         dv_neg [DIV_STAGES][3];
  logic [DIM_BITS-1:0]          dv_cl  [DIV_STAGES][3];
  logic signed [COORD_BITS-1:0] dv_pos [DIV_STAGES][3];
  logic                         dv_sel [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [DIM_BITS-1:0]          rem_src [3];
    logic [MAG_BITS-1:0]          qd_src  [3];
    logic                         neg_src [3];
    logic [DIM_BITS-1:0]          cl_src  [3];
    logic signed [COORD_BITS-1:0] pos_src [3];
    logic                         sel_src;
    logic [DIM_BITS-1:0]          rem_nx  [3];
    logic [MAG_BITS-1:0]          qd_nx   [3];

    if (i == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_src[k] = '0;
          qd_src[k]  = s2_qd[k];
          neg_src[k] = s2_neg[k];
          cl_src[k]  = s2_cl[k];
          pos_src[k] = s2_pos[k];
        end
        sel_src = s2_sel;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_src[k] = dv_rem[i-1][k];
          qd_src[k]  = dv_qd[i-1][k];
          neg_src[k] = dv_neg[i-1][k];
          cl_src[k]  = dv_cl[i-1][k];
          pos_src[k] = dv_pos[i-1][k];
        end
        sel_src = dv_sel[i-1];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
      pcbi_div_stage u_stage (
        .dim     (dim[k]),
        .rem_in  (rem_src[k]),
        .qd_in   (qd_src[k]),
        .rem_out (rem_nx[k]),
        .qd_out  (qd_nx[k])
      );
    end

    always_ff @(posedge clk) begin
      if (en[DV0+i]) begin
        for (int k = 0; k < 3; k++) begin
          dv_rem[i][k] <= rem_nx[k];
          dv_qd[i][k]  <= qd_nx[k];
          dv_neg[i][k] <= neg_src[k];
          dv_cl[i][k]  <= cl_src[k];
          dv_pos[i][k] <= pos_src[k];
        end
        dv_sel[i] <= sel_src;
      end
    end
  end

  // Stage P1: image shift and final bin per axis.
  logic signed [SHIFT_BITS-1:0] p1_shift [3];
  logic [DIM_BITS-1:0]          p1_bin   [3];
  logic signed [COORD_BITS-1:0] p1_pos   [3];
  logic                         p1_sel;

  always_ff @(posedge clk) begin
    if (en[P1]) begin
      for (int k = 0; k < 3; k++) begin
        if (!periodic[k]) begin
          p1_shift[k] <= '0;
          p1_bin[k]   <= dv_cl[DIV_STAGES-1][k];
        end else if (dv_neg[DIV_STAGES-1][k]) begin
          p1_shift[k] <= $signed({1'b0, dv_qd[DIV_STAGES-1][k]}) + SHIFT_BITS'(1);
          p1_bin[k]   <= dim[k] - DIM_BITS'(1) - dv_rem[DIV_STAGES-1][k];
        end else begin
          p1_shift[k] <= -$signed({1'b0, dv_qd[DIV_STAGES-1][k]});
          p1_bin[k]   <= dv_rem[DIV_STAGES-1][k];
        end
        p1_pos[k] <= dv_pos[DIV_STAGES-1][k];
      end
      p1_sel <= dv_sel[DIV_STAGES-1];
    end
  end

  // Stage P2: shift products and index terms.
  logic signed [WPROD_BITS-1:0] p2_wprod [3][3];
  logic signed [SHIFT_BITS-1:0] p2_shift [3];
  logic signed [COORD_BITS-1:0] p2_pos   [3];
  logic [DIM_BITS-1:0]          p2_t0;
  logic [2*DIM_BITS-1:0]        p2_t1;
  logic [3*DIM_BITS-1:0]        p2_t2;
  logic                         p2_sel;

  always_ff @(posedge clk) begin
    if (en[P2]) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          p2_wprod[k][j] <= p1_shift[k] * cvec[k][j];
        end
        p2_shift[k] <= p1_shift[k];
        p2_pos[k]   <= p1_pos[k];
      end
      p2_t0  <= p1_bin[0];
      p2_t1  <= p1_bin[1] * dim[0];
      p2_t2  <= p1_bin[2] * dim01;
      p2_sel <= p1_sel;
    end
  end

  // Stage P3: sums, saturation and output register.
  logic signed [WSUM_BITS-1:0] wsum [3];
  logic [IDX_SUM_BITS-1:0]     idx_sum;
  logic [IDX_BITS-1:0]         idx;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wsum[j] = WSUM_BITS'(p2_pos[j]) + WSUM_BITS'(p2_wprod[0][j])
              + WSUM_BITS'(p2_wprod[1][j]) + WSUM_BITS'(p2_wprod[2][j]);
    end
    idx_sum = IDX_SUM_BITS'(p2_t0) + IDX_SUM_BITS'(p2_t1) + IDX_SUM_BITS'(p2_t2);
    if (idx_sum >= IDX_SUM_BITS'(BIN_COUNT_LIMIT)) begin
      idx = IDX_BITS'(BIN_COUNT_LIMIT - 1);
    end else begin
      idx = idx_sum[IDX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[P3]) begin
      if (p2_sel) begin
        rsp_data.bin_index     <= idx;
        rsp_data.binned        <= 1'b1;
        rsp_data.image_shift_a <= sat_shift(p2_shift[0]);
        rsp_data.image_shift_b <= sat_shift(p2_shift[1]);
        rsp_data.image_shift_c <= sat_shift(p2_shift[2]);
        rsp_data.wrapped_x     <= sat_coord(wsum[0]);
        rsp_data.wrapped_y     <= sat_coord(wsum[1]);
        rsp_data.wrapped_z     <= sat_coord(wsum[2]);
      end else begin
        rsp_data.bin_index     <= '0;
        rsp_data.binned        <= 1'b0;
        rsp_data.image_shift_a <= '0;
        rsp_data.image_shift_b <= '0;
        rsp_data.image_shift_c <= '0;
        rsp_data.wrapped_x     <= p2_pos[0];
        rsp_data.wrapped_y     <= p2_pos[1];
        rsp_data.wrapped_z     <= p2_pos[2];
      end
    end
  end

endmodule

// ----- tb/periodic_cell_bin_index_unit_test.sv -----
// Self-checking testbench of the periodic cell bin index unit with its own bin predictor.
`timescale 1ns / 1ps

module periodic_cell_bin_index_unit_test;
  import pcbi_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  periodic_cell_bin_index_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [63:0] recip_rows [3];
  logic [62:0] cell_vectors [3];
  logic [32:0] geometry;

  rsp_t expected_bins [$];
  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int burst_left = 0;
  int wraps_seen = 0;

  function automatic longint saturate(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic rsp_t predict_bin(req_t r);
    rsp_t e;
    longint pos [3];
    longint wrapped [3];
    longint shift [3];
    longint bin [3];
    longint dim [3];
    longint acc;
    longint unsigned idx;
    pos[0] = longint'($signed(r.pos_x));
    pos[1] = longint'($signed(r.pos_y));
    pos[2] = longint'($signed(r.pos_z));
    for (int k = 0; k < 3; k++) begin
      wrapped[k] = pos[k];
      shift[k] = 0;
    end
    e = '0;
    if (!r.selected) begin
      e.wrapped_x = r.pos_x;
      e.wrapped_y = r.pos_y;
      e.wrapped_z = r.pos_z;
      return e;
    end
    for (int k = 0; k < 3; k++) begin
      dim[k] = longint'(geometry[10*k +: 10]);
      if (dim[k] < 1) dim[k] = 1;
    end
    for (int k = 0; k < 3; k++) begin
      acc = longint'($signed(recip_rows[k][63:48])) * 16384;
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(recip_rows[k][16*j +: 16])) * pos[j];
      bin[k] = acc >>> FRAC_SHIFT;
      if (geometry[30 + k]) begin
        if (bin[k] < 0) shift[k] = (-(bin[k] + 1)) / dim[k] + 1;
        else if (bin[k] >= dim[k]) shift[k] = -(bin[k] / dim[k]);
        bin[k] += shift[k] * dim[k];
      end else if (bin[k] < 0) begin
        bin[k] = 0;
      end else if (bin[k] >= dim[k]) begin
        bin[k] = dim[k] - 1;
      end
    end
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        wrapped[j] += shift[k] * longint'($signed(cell_vectors[k][21*j +: 21]));
    idx = bin[0] + bin[1] * dim[0] + bin[2] * dim[0] * dim[1];
    if (idx >= BIN_COUNT_LIMIT) idx = BIN_COUNT_LIMIT - 1;
    e.bin_index = idx[IDX_BITS-1:0];
    e.binned = 1'b1;
    e.image_shift_a = 16'(saturate(shift[0], 16));
    e.image_shift_b = 16'(saturate(shift[1], 16));
    e.image_shift_c = 16'(saturate(shift[2], 16));
    e.wrapped_x = 24'(saturate(wrapped[0], COORD_BITS));
    e.wrapped_y = 24'(saturate(wrapped[1], COORD_BITS));
    e.wrapped_z = 24'(saturate(wrapped[2], COORD_BITS));
    return e;
  endfunction

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < CFG_CELL_A) recip_rows[idx] = value;
    else if (idx < CFG_GEOMETRY) cell_vectors[idx - CFG_CELL_A] = value[62:0];
    else if (idx == CFG_GEOMETRY) geometry = value[32:0];
  endtask

  task automatic send_request(req_t r);
    rsp_t e;
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    e = predict_bin(r);
    if (e.image_shift_a != 0 || e.image_shift_b != 0 || e.image_shift_c != 0)
      wraps_seen++;
    expected_bins = {expected_bins, e};
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    wait (expected_bins.size() == 0);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [32:0] make_geometry(int dx, int dy, int dz, logic [2:0] per);
    return {per, 10'(dz), 10'(dy), 10'(dx)};
  endfunction

  function automatic req_t make_request(logic signed [23:0] x, logic signed [23:0] y,
                                        logic signed [23:0] z, logic sel);
    req_t r;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.selected = sel;
    return r;
  endfunction

  function automatic logic signed [23:0] random_coord();
    if ($urandom_range(0, 2) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 65536)) - 32768);
  endfunction

  function automatic logic [63:0] random_row(int axis);
    logic [63:0] row;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    for (int j = 0; j < 3; j++)
      row[16*j +: 16] = (j == axis) ? 16'($urandom_range(256, 8192))
                                    : 16'($signed($urandom_range(0, 512)) - 256);
    row[63:48] = 16'($signed($urandom_range(0, 2048)) - 1024);
    return row;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
        errors++;
      end else begin
        e = expected_bins.pop_front();
        results_checked++;
        check_field("bin_index", e.bin_index, rsp_data.bin_index);
        check_field("binned", e.binned, rsp_data.binned);
        check_field("image_shift_a", $signed(e.image_shift_a), $signed(rsp_data.image_shift_a));
        check_field("image_shift_b", $signed(e.image_shift_b), $signed(rsp_data.image_shift_b));
        check_field("image_shift_c", $signed(e.image_shift_c), $signed(rsp_data.image_shift_c));
        check_field("wrapped_x", $signed(e.wrapped_x), $signed(rsp_data.wrapped_x));
        check_field("wrapped_y", $signed(e.wrapped_y), $signed(rsp_data.wrapped_y));
        check_field("wrapped_z", $signed(e.wrapped_z), $signed(rsp_data.wrapped_z));
      end
    end
  end

  // The output side changes its stall behavior periodically, picking one of four ready modes.
  int ready_cycle = 0;
  int ready_mode = 0;
  always @(negedge clk) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 256 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= ($urandom_range(0, 9) < 7);
      2: rsp_ready <= ($urandom_range(0, 9) < 2);
      default: rsp_ready <= (ready_cycle % 7) < 3;
    endcase
  end

  task automatic test_reset_defaults();
    send_request(make_request(24'sh7FFFFF, 24'sh800000, 24'sd0, 1'b1));
    send_request(make_request(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1));
    send_request(make_request(24'sh123456, 24'sh800000, 24'sh000001, 1'b0));
    drain();
  endtask

  task automatic test_directed_wrap();
    // Coefficients of 4096: bin = position / 1024, four bins per axis.
    write_register(CFG_RECIP_X, 64'h0000_0000_0000_1000);
    write_register(CFG_RECIP_Y, 64'h0000_0000_1000_0000);
    write_register(CFG_RECIP_Z, 64'h0000_1000_0000_0000);
    write_register(CFG_CELL_A, 64'({21'sd0, 21'sd0, 21'sd4096}));
    write_register(CFG_CELL_B, 64'({21'sd0, 21'sd4096, 21'sd0}));
    write_register(CFG_CELL_C, 64'({21'sd4096, 21'sd0, 21'sd0}));
    write_register(CFG_GEOMETRY, 64'(make_geometry(4, 4, 4, 3'b011)));
    send_request(make_request(-24'sd1, -24'sd1024, -24'sd1, 1'b1));
    send_request(make_request(24'sd0, 24'sd4095, 24'sd4096, 1'b1));
    send_request(make_request(24'sd4096, 24'sd102400, -24'sd50000, 1'b1));
    send_request(make_request(24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1));
    send_request(make_request(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1));
    send_request(make_request(-24'sd9000, 24'sd9000, 24'sd1, 1'b0));
    drain();
    // Zero counts act as one; large counts give large indices, still below the index limit.
    write_register(CFG_GEOMETRY, 64'(make_geometry(0, 1023, 1023, 3'b100)));
    write_register(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(make_request(24'sd5000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1));
    send_request(make_request(24'sh800000, 24'sd1500000, -24'sd1, 1'b1));
    send_request(make_request(24'sd1, 24'sd1000000, 24'sd1048000, 1'b1));
    drain();
    // Extreme coefficients and cell vectors drive shifts and positions into saturation.
    write_register(CFG_RECIP_X, 64'h8000_7FFF_7FFF_7FFF);
    write_register(CFG_RECIP_Y, 64'h7FFF_8000_8000_8000);
    write_register(CFG_RECIP_Z, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CFG_CELL_A, 64'h7FFF_FFFF_FFFF_FFFF);
    write_register(CFG_CELL_B, {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000});
    write_register(CFG_CELL_C, 64'h0000_0000_0000_0000);
    write_register(CFG_GEOMETRY, 64'(make_geometry(1, 1023, 3, 3'b111)));
    send_request(make_request(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1));
    send_request(make_request(24'sh800000, 24'sh800000, 24'sh800000, 1'b1));
    send_request(make_request(24'sh7FFFFF, 24'sh800000, 24'sd0, 1'b1));
    send_request(make_request(24'sd3, -24'sd3, 24'sd1024, 1'b1));
    send_request(make_request(24'sh7FFFFF, 24'sh800000, 24'sh555555, 1'b0));
    drain();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      for (int k = 0; k < 3; k++)
        write_register(CFG_INDEX_BITS'(CFG_RECIP_X + k), random_row(k));
      for (int k = 0; k < 3; k++)
        write_register(CFG_INDEX_BITS'(CFG_CELL_A + k), {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0)
        write_register(CFG_GEOMETRY, {$urandom, $urandom});
      else
        write_register(CFG_GEOMETRY, 64'(make_geometry($urandom_range(0, 12),
                                                       $urandom_range(0, 12),
                                                       $urandom_range(0, 1023),
                                                       3'($urandom))));
      for (int i = 0; i < per_phase; i++)
        send_request(make_request(random_coord(), random_coord(), random_coord(),
                                  $urandom_range(0, 9) != 0));
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int k = 0; k < 3; k++) begin
      recip_rows[k] = '0;
      cell_vectors[k] = '0;
    end
    geometry = GEOM_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_directed_wrap();
    test_random_settings(8, 200);
    $display("Checked %0d results of %0d requests, %0d with a periodic image shift.",
             results_checked, requests_sent, wraps_seen);
    $display("Covered reset settings, directed wrap and saturation cases and 8 random settings.");
    if (errors == 0 && expected_bins.size() == 0) begin
      $display("PASS periodic_cell_bin_index_unit");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_bins.size());
      $display("FAIL periodic_cell_bin_index_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", expected_bins.size());
    $display("FAIL periodic_cell_bin_index_unit");
    $finish;
  end

endmodule
